// ===== rtl/skt_pkg.sv =====
// Shared types and constants for the sorted key table engine.
// Used by sorted_key_table_engine_core; depends on nothing.
`default_nettype none

package skt_pkg;

  // Field widths fixed by the request and result formats
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int POS_W    = 7;
  localparam int CNT_W    = 8;
  localparam int ENTRY_W  = KEY_W + PAY_W;
  localparam int OUT_W    = 24;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOCATE,
    S_COMPARE,
    S_VERIFY,
    S_ACT,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_key_table_engine_core.sv =====
// Top level of the sorted key table engine: sequencer, count and result register.
// Depends on skt_pkg and skt_ram.
`default_nettype none

// Keeps up to DEPTH unique signed keys with payloads in ascending key order in one
// single-port-read RAM. One request is worked at a time. A lookup is a binary search
// whose probes each issue the address, then compare the registered read data. Insert
// and remove then shift the entries behind the target one per cycle through the RAM's
// read and write ports. A full insert or the unused command goes straight to the
// finish state, which moves the result to the output register. The next request is
// taken while the previous result still waits on the output. Payloads are stored and
// moved but never read back out.
module sorted_key_table_engine_core #(
  parameter int DEPTH = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // command
  input  wire logic [63:0] in_tdata,   // [31:0] key, [63:32] payload
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [2:0] status, [9:3] position, [17:10] entry_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  skt_pkg::state_t state_r, state_nxt;

  logic [skt_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [skt_pkg::KEY_W-1:0]    key_r, key_nxt;
  logic [skt_pkg::PAY_W-1:0]    pay_r, pay_nxt;
  logic [CW-1:0]                lo_r, lo_nxt;
  logic [CW-1:0]                hi_r, hi_nxt;
  logic [CW-1:0]                mid_r, mid_nxt;
  logic [CW-1:0]                ptr_r, ptr_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         pend_r, pend_nxt;
  logic                         hit_r, hit_nxt;
  logic [skt_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [skt_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [skt_pkg::OUT_W-1:0]    out_data_r, out_data_nxt;

  logic                         in_acc;
  logic                         out_free;
  logic                         full;
  logic [CW-1:0]                mid;
  logic [CW:0]                  ptr_p1, ptr_p2, count_x;
  logic [CW+skt_pkg::POS_W-1:0] lo_ext;
  logic [CW+skt_pkg::CNT_W-1:0] cnt_ext;
  logic [skt_pkg::KEY_W-1:0]    rd_key;

  logic                         mem_we;
  logic [CW-1:0]                wr_idx, rd_idx;
  logic [skt_pkg::ENTRY_W-1:0]  mem_wdata, mem_rdata;

  // Entry memory: {payload, key}
  skt_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (skt_pkg::ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (rd_idx[AW-1:0]),
    .rdata (mem_rdata)
  );

  // Handshakes and helpers
  assign in_tready  = (state_r == skt_pkg::S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign full       = (count_r == CW'(DEPTH));
  assign mid        = lo_r + ((hi_r - lo_r) >> 1);
  assign ptr_p1     = {1'b0, ptr_r} + (CW+1)'(1);
  assign ptr_p2     = {1'b0, ptr_r} + (CW+1)'(2);
  assign count_x    = {1'b0, count_r};
  assign lo_ext     = {{skt_pkg::POS_W{1'b0}}, lo_r};
  assign cnt_ext    = {{skt_pkg::CNT_W{1'b0}}, count_r};
  assign rd_key     = mem_rdata[skt_pkg::KEY_W-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == skt_pkg::CMD_UNUSED) begin
            state_nxt = skt_pkg::S_DONE;
          end else if (in_tuser == skt_pkg::CMD_INSERT && full) begin
            state_nxt = skt_pkg::S_DONE;
          end else begin
            state_nxt = skt_pkg::S_LOCATE;
          end
        end
      end
      skt_pkg::S_LOCATE: begin
        if (lo_r < hi_r) begin
          state_nxt = skt_pkg::S_COMPARE;
        end else if (lo_r < count_r) begin
          state_nxt = skt_pkg::S_VERIFY;
        end else begin
          state_nxt = skt_pkg::S_ACT;
        end
      end
      skt_pkg::S_COMPARE: state_nxt = skt_pkg::S_LOCATE;
      skt_pkg::S_VERIFY:  state_nxt = skt_pkg::S_ACT;
      skt_pkg::S_ACT: begin
        case (cmd_r)
          skt_pkg::CMD_INSERT: state_nxt = hit_r ? skt_pkg::S_DONE : skt_pkg::S_SHIFT_UP;
          skt_pkg::CMD_REMOVE: state_nxt = hit_r ? skt_pkg::S_SHIFT_DN : skt_pkg::S_DONE;
          default:             state_nxt = skt_pkg::S_DONE;
        endcase
      end
      skt_pkg::S_SHIFT_UP: begin
        if (!pend_r && !(ptr_r > lo_r)) begin
          state_nxt = skt_pkg::S_DONE;
        end
      end
      skt_pkg::S_SHIFT_DN: begin
        if (!pend_r && !(ptr_p1 < count_x)) begin
          state_nxt = skt_pkg::S_DONE;
        end
      end
      skt_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = skt_pkg::S_IDLE;
        end
      end
      default: state_nxt = skt_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory controls and result register
  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    ptr_nxt       = ptr_r;
    count_nxt     = count_r;
    pend_nxt      = pend_r;
    hit_nxt       = hit_r;
    status_nxt    = status_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    wr_idx        = ptr_r;
    rd_idx        = mid;
    mem_wdata     = mem_rdata;
    case (state_r)
      skt_pkg::S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_tuser;
          key_nxt    = in_tdata[skt_pkg::KEY_W-1:0];
          pay_nxt    = in_tdata[skt_pkg::ENTRY_W-1:skt_pkg::KEY_W];
          lo_nxt     = '0;
          hi_nxt     = count_r;
          hit_nxt    = 1'b0;
          pos_nxt    = '0;
          status_nxt = (in_tuser == skt_pkg::CMD_INSERT) ? skt_pkg::ST_FULL
                                                        : skt_pkg::ST_NOTFOUND;
        end
      end
      // issue a probe, or the final equality read at the lower bound
      skt_pkg::S_LOCATE: begin
        mid_nxt = mid;
        rd_idx  = (lo_r < hi_r) ? mid : lo_r;
        hit_nxt = 1'b0;
      end
      skt_pkg::S_COMPARE: begin
        if ($signed(rd_key) < $signed(key_r)) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      skt_pkg::S_VERIFY: begin
        hit_nxt = (rd_key == key_r);
      end
      skt_pkg::S_ACT: begin
        pend_nxt = 1'b0;
        case (cmd_r)
          skt_pkg::CMD_INSERT: begin
            status_nxt = skt_pkg::ST_DUP;
            ptr_nxt    = count_r;
          end
          skt_pkg::CMD_SEARCH: begin
            status_nxt = hit_r ? skt_pkg::ST_FOUND : skt_pkg::ST_NOTFOUND;
            pos_nxt    = hit_r ? lo_ext[skt_pkg::POS_W-1:0] : '0;
          end
          skt_pkg::CMD_REMOVE: begin
            status_nxt = skt_pkg::ST_NOTFOUND;
            ptr_nxt    = lo_r;
          end
          default: status_nxt = skt_pkg::ST_NOTFOUND;
        endcase
      end
      // move entries up one slot from the top down, then drop in the new one
      skt_pkg::S_SHIFT_UP: begin
        if (pend_r) begin
          mem_we  = 1'b1;
          wr_idx  = ptr_r;
          ptr_nxt = ptr_r - CW'(1);
          if ((ptr_r - CW'(1)) > lo_r) begin
            rd_idx = ptr_r - CW'(2);
          end else begin
            pend_nxt = 1'b0;
          end
        end else if (ptr_r > lo_r) begin
          rd_idx   = ptr_r - CW'(1);
          pend_nxt = 1'b1;
        end else begin
          mem_we     = 1'b1;
          wr_idx     = lo_r;
          mem_wdata  = {pay_r, key_r};
          count_nxt  = count_r + CW'(1);
          status_nxt = skt_pkg::ST_INSERTED;
        end
      end
      // move entries down one slot from the hole upward
      skt_pkg::S_SHIFT_DN: begin
        if (pend_r) begin
          mem_we  = 1'b1;
          wr_idx  = ptr_r;
          ptr_nxt = ptr_p1[CW-1:0];
          if (ptr_p2 < count_x) begin
            rd_idx = ptr_p2[CW-1:0];
          end else begin
            pend_nxt = 1'b0;
          end
        end else if (ptr_p1 < count_x) begin
          rd_idx   = ptr_p1[CW-1:0];
          pend_nxt = 1'b1;
        end else begin
          count_nxt  = count_r - CW'(1);
          status_nxt = skt_pkg::ST_REMOVED;
        end
      end
      skt_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {6'b0, cnt_ext[skt_pkg::CNT_W-1:0], pos_r, status_r};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skt_pkg::S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    ptr_r      <= ptr_nxt;
    hit_r      <= hit_nxt;
    status_r   <= status_nxt;
    pos_r      <= pos_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef NO_ASSERTIONS
  // the table never holds more than DEPTH entries
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above DEPTH");

  // every memory write lands inside the table
  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (wr_idx < CW'(DEPTH)) && (wr_idx <= count_r))
    else $error("memory write outside the table");

  // a result appears only out of the finish state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == skt_pkg::S_DONE)
    else $error("result raised outside the finish state");
`endif

endmodule

`default_nettype wire

// ===== rtl/skt_ram.sv =====
// Simple dual-port entry memory: one write port, one read port, registered read.
// Standalone; sized by the top level of the sorted key table engine.
`default_nettype none

module skt_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
